[rtl/core/rmh_pkg.sv]
// rmh_pkg: shared types for the running median block
// no dependencies
package rmh_pkg;

  // controller commands to the datapath
  typedef struct packed {
    logic load;      // capture request and decide the case
    logic step;      // advance one heap operation step
  } rmh_cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic busy;      // heap work in flight
    logic done;      // result formed, ready to present
  } rmh_sts_t;

endpackage

[rtl/core/rmh_ctrl.sv]
// rmh_ctrl: request sequencer for the running median block
// depends on rmh_pkg
module rmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rmh_pkg::rmh_cmd_t cmd_o,
  input  rmh_pkg::rmh_sts_t sts_i
);
  import rmh_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWork = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle) && !sts_i.busy;
  assign out_valid_o = (state_q == StOut);
  assign cmd_o.load  = in_ready_o && in_valid_i;
  assign cmd_o.step  = (state_q == StWork);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (cmd_o.load) state_d = StWork;
      StWork: if (sts_i.done) state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

[rtl/core/rmh_dp.sv]
// rmh_dp: heap memories, counts, sift engine and median arithmetic
// depends on rmh_pkg
module rmh_dp #(
  parameter int HeapDepth   = 512,
  parameter int SampleWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rmh_pkg::rmh_cmd_t      cmd_i,
  output rmh_pkg::rmh_sts_t      sts_o,
  input  logic [SampleWidth-1:0] sample_i,
  input  logic                   last_i,
  output logic [SampleWidth-1:0] median_o,
  output logic                   overflow_o,
  output logic                   last_o
);
  import rmh_pkg::*;

  localparam int AW = (HeapDepth > 2) ? $clog2(HeapDepth) : 1;
  localparam int CW = $clog2(HeapDepth + 1);
  localparam logic [CW-1:0] Full = CW'(HeapDepth);

  // sequencer steps
  localparam logic [3:0] PIdle  = 4'd0;
  localparam logic [3:0] PTops  = 4'd1;  // read both tops
  localparam logic [3:0] PTopW  = 4'd2;  // tops available
  localparam logic [3:0] PUpRd  = 4'd3;  // sift up: read parent
  localparam logic [3:0] PUpCmp = 4'd4;
  localparam logic [3:0] PDnRd  = 4'd5;  // sift down: read children
  localparam logic [3:0] PDnCmp = 4'd6;
  localparam logic [3:0] PMed   = 4'd7;  // read tops for median
  localparam logic [3:0] PMedW  = 4'd8;
  localparam logic [3:0] PMedC  = 4'd9;
  localparam logic [3:0] PDone  = 4'd10;

  // heap jobs
  localparam logic [1:0] JobNone = 2'd0;
  localparam logic [1:0] JobPush = 2'd1;  // push only
  localparam logic [1:0] JobMove = 2'd2;  // push then replace top

  logic [3:0] ph_q;

  // two memories, one per heap; two read ports and one write port each
  logic [SampleWidth-1:0] lo_mem [HeapDepth];
  logic [SampleWidth-1:0] up_mem [HeapDepth];
  logic [AW-1:0] lo_ra, lo_rb, up_ra, up_rb, wa;
  logic [SampleWidth-1:0] lo_da, lo_db, up_da, up_db, wd;
  logic lo_we, up_we;

  always_ff @(posedge clk_i) begin
    if (lo_we) lo_mem[wa] <= wd;
    if (up_we) up_mem[wa] <= wd;
    lo_da <= lo_mem[lo_ra];
    lo_db <= lo_mem[lo_rb];
    up_da <= up_mem[up_ra];
    up_db <= up_mem[up_rb];
  end

  logic [CW-1:0] lc_q, uc_q;
  logic signed [SampleWidth-1:0] med_q, x_q, v_q;
  logic last_q, ovf_q;
  logic [1:0] job_q;
  logic op_lo_q;            // current sift heap is lower
  logic [AW:0] i_q;         // current index
  logic [CW-1:0] cnt_q;     // active count for sift down
  logic mode_q;             // 0 single-top median, 1 average
  logic med_lo_q;           // single-top from lower heap

  // sift helpers
  logic signed [SampleWidth-1:0] ra_v, rb_v;
  assign ra_v = op_lo_q ? lo_da : up_da;
  assign rb_v = op_lo_q ? lo_db : up_db;
  function automatic logic ahd(input logic signed [SampleWidth-1:0] a,
                               input logic signed [SampleWidth-1:0] b,
                               input logic mx);
    return mx ? (a > b) : (a < b);
  endfunction

  logic [AW:0] par, lch, rch;
  assign par = (i_q - 1'b1) >> 1;
  assign lch = {i_q[AW-1:0], 1'b1};
  assign rch = lch + 1'b1;

  logic signed [SampleWidth:0] sum;
  assign sum = {lo_da[SampleWidth-1], lo_da} + {up_da[SampleWidth-1], up_da};
  logic signed [SampleWidth:0] half;
  assign half = (sum + {{SampleWidth{1'b0}}, sum[SampleWidth]}) >>> 1;

  logic dn_right, dn_swap;
  logic signed [SampleWidth-1:0] best_v;
  assign dn_right = ({1'b0, rch} < {1'b0, cnt_q}) && ahd(rb_v, ra_v, op_lo_q);
  assign best_v   = dn_right ? rb_v : ra_v;
  assign dn_swap  = ahd(best_v, v_q, op_lo_q);

  // case decision on the new sample
  logic x_lt, x_gt, refuse;
  assign x_lt   = (x_q < med_q);
  assign x_gt   = (x_q > med_q);
  assign refuse = (lc_q > uc_q)  ? (uc_q >= Full)
                : (lc_q == uc_q) ? (x_lt ? (lc_q >= Full) : (uc_q >= Full))
                : (lc_q >= Full);

  // read addresses and writes
  always_comb begin
    lo_ra = '0; lo_rb = '0; up_ra = '0; up_rb = '0;
    lo_we = 1'b0; up_we = 1'b0; wa = '0; wd = v_q;
    case (ph_q)
      PUpRd: begin
        lo_ra = par[AW-1:0]; up_ra = par[AW-1:0];
      end
      PUpCmp: begin
        wa = i_q[AW-1:0];
        if (i_q != '0 && ahd(v_q, ra_v, op_lo_q)) wd = ra_v;
        lo_we = op_lo_q; up_we = !op_lo_q;
      end
      PDnRd: begin
        lo_ra = lch[AW-1:0]; lo_rb = rch[AW-1:0];
        up_ra = lch[AW-1:0]; up_rb = rch[AW-1:0];
      end
      PDnCmp: begin
        wa = i_q[AW-1:0];
        if ({1'b0, lch} < {1'b0, cnt_q} && dn_swap) wd = best_v;
        lo_we = op_lo_q; up_we = !op_lo_q;
      end
      default: ;
    endcase
  end

  assign sts_o.busy = (ph_q != PIdle);
  assign sts_o.done = (ph_q == PDone);
  assign median_o   = med_q;
  assign overflow_o = ovf_q;
  assign last_o     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PIdle; lc_q <= '0; uc_q <= '0; med_q <= '0;
      ovf_q <= 1'b0; last_q <= 1'b0; job_q <= JobNone;
      op_lo_q <= 1'b0; i_q <= '0; cnt_q <= '0; mode_q <= 1'b0;
      med_lo_q <= 1'b0; x_q <= '0; v_q <= '0;
    end else if (ph_q == PIdle || cmd_i.step) begin
      unique case (ph_q)
        PIdle: if (cmd_i.load) begin
          x_q <= sample_i; last_q <= last_i; ph_q <= PTops;
          if (last_q) begin
            lc_q <= '0; uc_q <= '0; med_q <= '0;
          end
        end
        PTops: ph_q <= PTopW;
        PTopW: begin
          ovf_q <= refuse;
          ph_q  <= refuse ? PDone : PUpRd;
          if (lc_q > uc_q) begin
            mode_q <= 1'b1;
            job_q  <= x_lt ? JobMove : JobPush;
          end else if (lc_q == uc_q) begin
            mode_q <= 1'b0; job_q <= JobPush; med_lo_q <= x_lt;
          end else begin
            mode_q <= 1'b1;
            job_q  <= x_gt ? JobMove : JobPush;
          end
          // start push: index is old count
          op_lo_q <= (lc_q > uc_q) ? 1'b0 : (lc_q == uc_q) ? x_lt : 1'b1;
          i_q <= (lc_q > uc_q) ? (AW+1)'(uc_q) :
                 (lc_q == uc_q) ? (x_lt ? (AW+1)'(lc_q) : (AW+1)'(uc_q))
                                : (AW+1)'(lc_q);
          v_q <= (lc_q > uc_q) ? (x_lt ? lo_da : x_q)
               : (lc_q == uc_q) ? x_q : (x_gt ? up_da : x_q);
        end
        PUpRd: ph_q <= PUpCmp;
        PUpCmp: begin
          if (i_q != '0 && ahd(v_q, ra_v, op_lo_q)) begin
            i_q <= par; ph_q <= PUpRd;
          end else begin
            // push finished: commit count
            if (op_lo_q) lc_q <= lc_q + 1'b1; else uc_q <= uc_q + 1'b1;
            if (job_q == JobMove) begin
              op_lo_q <= !op_lo_q; i_q <= '0; v_q <= x_q;
              cnt_q <= op_lo_q ? uc_q : lc_q;
              ph_q <= PDnRd;
            end else ph_q <= PMed;
          end
        end
        PDnRd: ph_q <= PDnCmp;
        PDnCmp: begin
          if ({1'b0, lch} < {1'b0, cnt_q} && dn_swap) begin
            i_q <= dn_right ? rch : lch; ph_q <= PDnRd;
          end else ph_q <= PMed;
        end
        PMed: ph_q <= PMedW;
        PMedW: ph_q <= PMedC;
        PMedC: begin
          if (mode_q) med_q <= half[SampleWidth-1:0];
          else med_q <= med_lo_q ? lo_da : up_da;
          ph_q <= PDone;
        end
        PDone: ph_q <= PIdle;
        default: ph_q <= PIdle;
      endcase
    end
  end

endmodule

[rtl/core/running_median_two_heaps.sv]
// running_median_two_heaps: streaming running median over two heaps
// per sample: push and sift up, for a move replace the other top and sift down
// one sample at a time until its result is taken; the sift loops set the pace
// reset: counts and median clear at once; heap memory needs no clearing
// depends on rmh_pkg, rmh_ctrl, rmh_dp
module running_median_two_heaps #(
  parameter int HeapDepth   = 512,
  parameter int SampleWidth = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((SampleWidth+7)/8)*8-1:0] s_axis_tdata, // sample
  input  logic s_axis_tlast,                              // last_sample
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [((SampleWidth+8)/8)*8-1:0] m_axis_tdata, // median, overflow
  output logic m_axis_tlast                               // last_result
);
  import rmh_pkg::*;

  localparam int OW = ((SampleWidth + 8) / 8) * 8;

  rmh_cmd_t cmd;
  rmh_sts_t sts;
  logic [SampleWidth-1:0] median;
  logic ovf;

  rmh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  rmh_dp #(.HeapDepth(HeapDepth), .SampleWidth(SampleWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .sample_i(s_axis_tdata[SampleWidth-1:0]), .last_i(s_axis_tlast),
    .median_o(median), .overflow_o(ovf), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = OW'({ovf, median});

  // result only presented after datapath work completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(sts.done)) else $error("early result");
  // no new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("overlap");

endmodule

[tb/sv/running_median_two_heaps_test.sv]
// running_median_two_heaps_test: stream testbench for the two-heap running median
// checks results against a two-heap predictor or typed rows under random idling
// depends on running_median_two_heaps
`timescale 1ns / 100ps

module running_median_two_heaps_test;

  localparam int Depth = 512;

  // one result as the block presents it
  typedef struct {
    logic [31:0] med;
    logic        ovf;
    logic        last;
  } median_res_t;

  // one row of the directed stimulus
  typedef struct {
    int          smp;
    bit          last;
    bit          typed;
    median_res_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;
  logic        m_tlast;

  running_median_two_heaps uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),  // sample
    .s_axis_tlast (s_tlast),  // last_sample
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),  // median, overflow
    .m_axis_tlast (m_tlast)   // last_result
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state: index 0 lower half (max-heap), 1 upper half (min-heap)
  int heap_mem [2][Depth];
  int heap_cnt [2];
  int cur_median;

  median_res_t median_q[$];
  dir_row_t    dir_rows[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_ovf = 0;
  int n_bad = 0;

  function automatic bit ahead(int a, int b, int side);
    return (side == 0) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_push(int side, int v);
    int i;
    int p;
    int t;
    i = heap_cnt[side];
    heap_mem[side][i] = v;
    heap_cnt[side] = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ahead(heap_mem[side][i], heap_mem[side][p], side)) break;
      t = heap_mem[side][i];
      heap_mem[side][i] = heap_mem[side][p];
      heap_mem[side][p] = t;
      i = p;
    end
  endfunction

  function automatic void heap_swap_top(int side, int v);
    int i;
    int l;
    int b;
    int t;
    i = 0;
    heap_mem[side][0] = v;
    forever begin
      l = 2 * i + 1;
      b = l;
      if (l >= heap_cnt[side]) break;
      if (l + 1 < heap_cnt[side] && ahead(heap_mem[side][l+1], heap_mem[side][l], side))
        b = l + 1;
      if (!ahead(heap_mem[side][b], heap_mem[side][i], side)) break;
      t = heap_mem[side][i];
      heap_mem[side][i] = heap_mem[side][b];
      heap_mem[side][b] = t;
      i = b;
    end
  endfunction

  // sum at wide precision, halved toward zero
  function automatic int tops_average();
    longint s;
    s = longint'(heap_mem[0][0]) + longint'(heap_mem[1][0]);
    return int'(s / 2);
  endfunction

  function automatic median_res_t predict_median(int x, bit last);
    median_res_t r;
    bit refused;
    refused = 1'b0;
    if (heap_cnt[0] > heap_cnt[1]) begin
      if (heap_cnt[1] >= Depth) refused = 1'b1;
      else begin
        if (x < cur_median) begin
          heap_push(1, heap_mem[0][0]);
          heap_swap_top(0, x);
        end else heap_push(1, x);
        cur_median = tops_average();
      end
    end else if (heap_cnt[0] == heap_cnt[1]) begin
      if (x < cur_median) begin
        if (heap_cnt[0] >= Depth) refused = 1'b1;
        else begin
          heap_push(0, x);
          cur_median = heap_mem[0][0];
        end
      end else begin
        if (heap_cnt[1] >= Depth) refused = 1'b1;
        else begin
          heap_push(1, x);
          cur_median = heap_mem[1][0];
        end
      end
    end else begin
      if (heap_cnt[0] >= Depth) refused = 1'b1;
      else begin
        if (x > cur_median) begin
          heap_push(0, heap_mem[1][0]);
          heap_swap_top(1, x);
        end else heap_push(0, x);
        cur_median = tops_average();
      end
    end
    r.med = cur_median;
    r.ovf = refused;
    r.last = last;
    if (last) begin
      heap_cnt[0] = 0;
      heap_cnt[1] = 0;
      cur_median = 0;
    end
    return r;
  endfunction

  // present one request and wait for it to be taken
  task automatic send_sample(int x, bit last, bit typed, median_res_t typed_res);
    median_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    r = predict_median(x, last);
    median_q.push_back(typed ? typed_res : r);
    n_sent++;
  endtask

  task automatic send_plain(int x, bit last);
    median_res_t nores;
    nores = '{default: '0};
    send_sample(x, last, 1'b0, nores);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(100) - 50;
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return cur_median + $urandom_range(6) - 3;
    endcase
  endfunction

  task automatic add_row(int x, bit last, bit typed, int med);
    dir_row_t d;
    d.smp = x;
    d.last = last;
    d.typed = typed;
    d.res.med = med;
    d.res.ovf = 1'b0;
    d.res.last = last;
    dir_rows.push_back(d);
  endtask

  // result checker
  always @(posedge clk_i) begin
    median_res_t e;
    if (m_tvalid && m_tready) begin
      n_got++;
      if (m_tdata[32]) n_ovf++;
      if (median_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result median=%h", m_tdata[31:0]);
      end else begin
        e = median_q.pop_front();
        if (m_tdata[31:0] !== e.med || m_tdata[32] !== e.ovf || m_tlast !== e.last
            || m_tdata[39:33] !== 7'd0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp med=%h ovf=%b last=%b, got med=%h ovf=%b last=%b",
                     e.med, e.ovf, e.last, m_tdata[31:0], m_tdata[32], m_tlast);
        end
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #20_000_000;
    $display("running_median_two_heaps_test NOT OK");
    $finish;
  end

  initial begin
    int len;
    heap_cnt[0] = 0;
    heap_cnt[1] = 0;
    cur_median = 0;
    // directed rows: extremes, even-count truncation, every branch, last clearing
    add_row(0, 0, 1, 0);
    add_row(32'h7fff_ffff, 0, 1, 1073741823);
    add_row(32'h8000_0000, 1, 1, 0);
    add_row(32'h8000_0000, 0, 1, 32'h8000_0000);
    add_row(32'h7fff_ffff, 1, 1, 0);
    add_row(32'h7fff_ffff, 0, 1, 32'h7fff_ffff);
    add_row(32'h7fff_ffff, 1, 1, 32'h7fff_ffff);
    add_row(-1, 0, 1, -1);
    add_row(-1, 1, 1, -1);
    add_row(5, 0, 0, 0);
    add_row(3, 0, 0, 0);
    add_row(9, 0, 0, 0);
    add_row(1, 0, 0, 0);
    add_row(-7, 0, 0, 0);
    add_row(100, 0, 0, 0);
    add_row(-100, 0, 0, 0);
    add_row(42, 0, 0, 0);
    add_row(-3, 0, 0, 0);
    add_row(0, 1, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_sample(dir_rows[i].smp, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // heap full: one long run past capacity, ending on a refused last sample
    for (int i = 0; i < 1028; i++) send_plain(rand_sample(), i == 1027);
    drain();

    // short runs under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 20 : 0;
      stall_pct = (ph == 2) ? 47 : (ph == 3) ? 20 : 0;
      for (int n = 0; n < 20; n += len) begin
        len = $urandom_range(12, 1);
        for (int k = 0; k < len; k++)
          send_plain(rand_sample(), (k == len - 1) || ($urandom_range(19) == 0));
      end
      drain();
    end

    $display("sent %0d samples, got %0d medians, %0d refused by full heaps",
             n_sent, n_got, n_ovf);
    if (n_bad == 0) begin
      $display("running_median_two_heaps_test OK");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("running_median_two_heaps_test NOT OK");
    end
    $finish;
  end

endmodule

[running_median_two_heaps.f]
rtl/core/rmh_pkg.sv
rtl/core/rmh_ctrl.sv
rtl/core/rmh_dp.sv
rtl/core/running_median_two_heaps.sv
tb/sv/running_median_two_heaps_test.sv
